// File: rtl/iste_pkg.sv
// Shared types and constants for the index set table engine.
`timescale 1ns / 1ps

package iste_pkg;

    // Default store depth and stored index width.
    localparam int CAPACITY_DEF    = 256;
    localparam int INDEX_WIDTH_DEF = 24;

    // Operation codes carried by the kind field of a request.
    typedef enum logic [1:0] {
        KIND_APPEND  = 2'd0,
        KIND_FIND    = 2'd1,
        KIND_REMOVE  = 2'd2,
        KIND_LARGEST = 2'd3
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the request fields
        logic setup;   // check the request, prepare pointers, do an append
        logic run;     // scan or copy phase is active
        logic finish;  // commit the count and load the result registers
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run_done;  // every read issued and the last one consumed
    } dp_status_t;

endpackage

// File: rtl/iste_ctrl.sv
// Controller state machine of the index set table engine.
`timescale 1ns / 1ps

module iste_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  iste_pkg::dp_status_t  status,
    output iste_pkg::ctl_cmd_t    cmd,
    output logic                  busy,
    output logic                  done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    // Commands decoded from the current state and the request handshake.
    always_comb
    begin
        cmd.load   = start && !busy_reg;
        cmd.setup  = (state_reg == ST_SETUP);
        cmd.run    = (state_reg == ST_RUN);
        cmd.finish = (state_reg == ST_RUN) && status.run_done;
    end

    // State and registered handshake outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_SETUP;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_SETUP:
                begin
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (status.run_done)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    // A result strobe comes with the engine free for the next request.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result strobe while busy");

    // An accepted request makes the engine busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("request accepted but engine not busy");

    // The strobe lasts exactly one cycle per request.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

endmodule

// File: rtl/iste_datapath.sv
// Datapath of the index set table engine: store, pointers, compare and result registers.
`timescale 1ns / 1ps

module iste_datapath
#(
    parameter int CAPACITY    = iste_pkg::CAPACITY_DEF,
    parameter int INDEX_WIDTH = iste_pkg::INDEX_WIDTH_DEF,
    localparam int AW         = $clog2(CAPACITY),
    localparam int CW         = $clog2(CAPACITY + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  iste_pkg::ctl_cmd_t          cmd,
    output iste_pkg::dp_status_t        status,
    input  logic [1:0]                  kind,
    input  logic [INDEX_WIDTH-1:0]      value,
    input  logic [AW-1:0]               first_pos,
    input  logic [AW-1:0]               last_pos,
    output logic signed [AW:0]          position,
    output logic signed [INDEX_WIDTH:0] largest_index,
    output logic [CW-1:0]               fill_count,
    output logic                        error
);

    // Entry store; read data is registered.
    logic [INDEX_WIDTH-1:0] mem [CAPACITY];

    // Captured request fields.
    iste_pkg::kind_t        kind_reg;
    logic [INDEX_WIDTH-1:0] val_reg;
    logic [AW-1:0]          first_reg;
    logic [AW-1:0]          last_reg;

    // Control state.
    logic [CW-1:0] count_reg,  count_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] rd_end_reg, rd_end_next;
    logic          rd_valid_reg, rd_valid_next;

    // Per-request working registers.
    logic [CW-1:0]          span_reg,   span_next;
    logic                   err_reg,    err_next;
    logic [AW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]          rd_pos_reg, rd_pos_next;
    logic                   found_reg,  found_next;
    logic [AW-1:0]          pos_reg,    pos_next;
    logic                   any_reg,    any_next;
    logic [INDEX_WIDTH-1:0] best_reg,   best_next;
    logic [INDEX_WIDTH-1:0] rd_data_reg;

    // Result registers.
    logic signed [AW:0]          position_reg;
    logic signed [INDEX_WIDTH:0] largest_reg;
    logic [CW-1:0]               fill_count_reg;
    logic                        error_reg;

    // Range arithmetic for a remove.
    logic [CW-1:0] first_ext;
    logic [CW-1:0] after;
    logic [CW-1:0] span;
    logic [CW-1:0] tail;
    logic [CW-1:0] moves;
    logic          bad_range;
    logic          full;
    logic [CW-1:0] final_count;

    // Memory port controls.
    logic                   rd_en;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [INDEX_WIDTH-1:0] wr_data;
    logic                   append_wr;
    logic                   copy_wr;

    assign first_ext = CW'(first_reg);
    assign after     = CW'(last_reg) + CW'(1);
    assign span      = after - first_ext;
    assign tail      = count_reg - after;
    assign moves     = (tail >= span) ? span : tail;
    assign bad_range = (first_reg > last_reg) || (CW'(last_reg) >= count_reg);
    assign full      = (count_reg == CW'(CAPACITY));

    // A read is issued each run cycle until the pointer meets the end.
    assign rd_en           = cmd.run && (rd_ptr_reg < rd_end_reg);
    assign status.run_done = (rd_ptr_reg == rd_end_reg) && !rd_valid_reg;

    // Write port: an append in setup, or a copy of the entry just read.
    assign append_wr = cmd.setup && (kind_reg == iste_pkg::KIND_APPEND) && !full;
    assign copy_wr   = rd_valid_reg && (kind_reg == iste_pkg::KIND_REMOVE);
    assign wr_en     = append_wr || copy_wr;
    assign wr_addr   = append_wr ? count_reg[AW-1:0] : wr_ptr_reg;
    assign wr_data   = append_wr ? val_reg : rd_data_reg;

    // Count after the request completes.
    assign final_count = (kind_reg == iste_pkg::KIND_REMOVE && !err_reg) ?
                         (count_reg - span_reg) : count_reg;

    // Next-state logic for pointers, flags and the running compare.
    always_comb
    begin
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_end_next   = rd_end_reg;
        rd_valid_next = rd_en;
        span_next     = span_reg;
        err_next      = err_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_pos_next   = rd_pos_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        any_next      = any_reg;
        best_next     = best_reg;

        if (cmd.setup)
        begin
            found_next = 1'b0;
            any_next   = 1'b0;
            span_next  = span;
            case (kind_reg)
                iste_pkg::KIND_APPEND:
                begin
                    err_next    = full;
                    rd_ptr_next = '0;
                    rd_end_next = '0;
                    if (!full)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                iste_pkg::KIND_REMOVE:
                begin
                    err_next    = bad_range;
                    wr_ptr_next = first_reg;
                    if (bad_range)
                    begin
                        rd_ptr_next = '0;
                        rd_end_next = '0;
                    end
                    else
                    begin
                        rd_ptr_next = count_reg - moves;
                        rd_end_next = count_reg;
                    end
                end
                default:
                begin
                    err_next    = 1'b0;
                    rd_ptr_next = '0;
                    rd_end_next = count_reg;
                end
            endcase
        end

        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + CW'(1);
            rd_pos_next = rd_ptr_reg[AW-1:0];
        end

        if (rd_valid_reg)
        begin
            case (kind_reg)
                iste_pkg::KIND_FIND:
                begin
                    if (!found_reg && (rd_data_reg == val_reg))
                    begin
                        found_next = 1'b1;
                        pos_next   = rd_pos_reg;
                    end
                end
                iste_pkg::KIND_LARGEST:
                begin
                    if (!any_reg || (rd_data_reg > best_reg))
                    begin
                        any_next  = 1'b1;
                        best_next = rd_data_reg;
                    end
                end
                iste_pkg::KIND_REMOVE:
                begin
                    wr_ptr_next = wr_ptr_reg + AW'(1);
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.finish)
        begin
            count_next = final_count;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rd_ptr_reg   <= '0;
            rd_end_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            rd_ptr_reg   <= rd_ptr_next;
            rd_end_reg   <= rd_end_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Working registers and request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= iste_pkg::kind_t'(kind);
            val_reg   <= value;
            first_reg <= first_pos;
            last_reg  <= last_pos;
        end
        span_reg   <= span_next;
        err_reg    <= err_next;
        wr_ptr_reg <= wr_ptr_next;
        rd_pos_reg <= rd_pos_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        any_reg    <= any_next;
        best_reg   <= best_next;
    end

    // Store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_ptr_reg[AW-1:0]];
        end
    end

    // Result registers, loaded when the request completes.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            position_reg   <= found_reg ? {1'b0, pos_reg} : '1;
            largest_reg    <= (kind_reg == iste_pkg::KIND_LARGEST && any_reg) ?
                              {1'b0, best_reg} : '1;
            fill_count_reg <= final_count;
            error_reg      <= err_reg;
        end
    end

    assign position      = position_reg;
    assign largest_index = largest_reg;
    assign fill_count    = fill_count_reg;
    assign error         = error_reg;

    // The fill count never exceeds the store depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    // Copy destinations stay below the tail entries still to be read.
    a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
        copy_wr |-> (wr_ptr_reg < rd_pos_reg))
        else $error("remove copy overwrites its own source");

    // Results are committed only after the last read has been consumed.
    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!rd_en && !rd_valid_reg))
        else $error("finish while reads are in flight");

endmodule

// File: rtl/index_set_table_engine.sv
// Top level of the index set table engine.
`timescale 1ns / 1ps

// Holds an unordered set of indices in a single-port-per-direction store with a
// fill count. A request is taken when start is high and busy is low; its one
// result appears for a single cycle with done high and must be taken then; the
// result registers keep it until the next request completes. An append, a
// rejected remove, a remove that only truncates and any find or largest-index
// report on an empty set issue no store read. Otherwise the store's one read
// per cycle walks the filled entries for a find or largest-index report, or
// for a remove that copies, the tail entries to be copied into the hole, where
// the tail is the number of entries after the range; the last read is consumed
// before done. Busy drops together with done, so a new request may start then.
// Entries need no clearing after reset: only positions below the count are
// ever read. A find reports the lowest matching position; a remove that
// reaches the end of the filled part just truncates.

module index_set_table_engine
#(
    parameter int CAPACITY    = iste_pkg::CAPACITY_DEF,
    parameter int INDEX_WIDTH = iste_pkg::INDEX_WIDTH_DEF,
    localparam int AW         = $clog2(CAPACITY),
    localparam int CW         = $clog2(CAPACITY + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  kind,
    input  logic [INDEX_WIDTH-1:0]      value,
    input  logic [AW-1:0]               first_pos,
    input  logic [AW-1:0]               last_pos,
    output logic                        done,
    output logic signed [AW:0]          position,
    output logic signed [INDEX_WIDTH:0] largest_index,
    output logic [CW-1:0]               fill_count,
    output logic                        error
);

    iste_pkg::ctl_cmd_t   cmd;
    iste_pkg::dp_status_t status;

    // Sequencing of each request.
    iste_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Store, scan and copy logic.
    iste_datapath
    #(
        .CAPACITY    (CAPACITY),
        .INDEX_WIDTH (INDEX_WIDTH)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .kind          (kind),
        .value         (value),
        .first_pos     (first_pos),
        .last_pos      (last_pos),
        .position      (position),
        .largest_index (largest_index),
        .fill_count    (fill_count),
        .error         (error)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the index set table engine.
`timescale 1ns / 1ps

module tb;

    localparam int CAPACITY    = 256;
    localparam int DIRECTED    = 25;
    localparam int RANDOM_REQS = 1150;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SHOWN_MAX   = 10;

    // Short local names for the operation codes.
    localparam iste_pkg::kind_t OP_APPEND  = iste_pkg::KIND_APPEND;
    localparam iste_pkg::kind_t OP_FIND    = iste_pkg::KIND_FIND;
    localparam iste_pkg::kind_t OP_REMOVE  = iste_pkg::KIND_REMOVE;
    localparam iste_pkg::kind_t OP_LARGEST = iste_pkg::KIND_LARGEST;

    // All-ones patterns that stand for -1 in the signed result fields.
    localparam logic [8:0]  NO_POSITION = 9'h1FF;
    localparam logic [24:0] NO_INDEX    = 25'h1FFFFFF;

    // Traffic shapes for the random part.
    localparam int SHAPE_MIXED = 0;
    localparam int SHAPE_FILL  = 1;
    localparam int SHAPE_DRAIN = 2;

    typedef struct packed {
        int          tag;
        logic [8:0]  pos;
        logic [24:0] big;
        logic [8:0]  cnt;
        logic        err;
    } outcome_t;

    typedef struct packed {
        iste_pkg::kind_t op;
        logic [23:0]     val;
        logic [7:0]      lo;
        logic [7:0]      hi;
        logic            typed;
        logic [8:0]      pos;
        logic [24:0]     big;
        logic [8:0]      cnt;
        logic            err;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  kind = OP_APPEND;
    logic [23:0] value = '0;
    logic [7:0]  first_pos = '0;
    logic [7:0]  last_pos = '0;
    logic        busy;
    logic        done;
    logic signed [8:0]  position;
    logic signed [24:0] largest_index;
    logic [8:0]  fill_count;
    logic        error;

    // Mirror of the set kept by the predictor.
    logic [23:0] set_entries [CAPACITY];
    int          set_count = 0;

    outcome_t    results_due [$];
    plan_row_t   plan [DIRECTED];
    int          requests_sent = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          kind_seen [4] = '{0, 0, 0, 0};
    int          full_rejects = 0;
    int          bad_ranges = 0;
    int          truncations = 0;
    int          fills_moved = 0;
    int          finds_hit = 0;
    int          peak_count = 0;

    index_set_table_engine u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .value        (value),
        .first_pos    (first_pos),
        .last_pos     (last_pos),
        .done         (done),
        .position     (position),
        .largest_index(largest_index),
        .fill_count   (fill_count),
        .error        (error)
    );

    always #5 clk = ~clk;

    // Apply one accepted request to the mirror and return what the engine must report.
    function automatic outcome_t apply_to_set(iste_pkg::kind_t op, logic [23:0] v,
                                              logic [7:0] lo, logic [7:0] hi);
        outcome_t r;
        int k;
        int span;
        int tail;
        int moves;
        logic [23:0] best;
        r.tag = 0;
        r.pos = NO_POSITION;
        r.big = NO_INDEX;
        r.err = 1'b0;
        best  = '0;
        kind_seen[op]++;
        case (op)
            OP_APPEND:
            begin
                if (set_count >= CAPACITY)
                begin
                    r.err = 1'b1;
                    full_rejects++;
                end
                else
                begin
                    set_entries[set_count] = v;
                    set_count++;
                end
            end
            OP_FIND:
            begin
                for (k = 0; k < set_count; k++)
                begin
                    if (set_entries[k] == v)
                    begin
                        r.pos = 9'(k);
                        finds_hit++;
                        break;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (lo > hi || int'(hi) >= set_count)
                begin
                    r.err = 1'b1;
                    bad_ranges++;
                end
                else
                begin
                    // Fill the hole from the tail; a range at the end only truncates.
                    span  = int'(hi) + 1 - int'(lo);
                    tail  = set_count - (int'(hi) + 1);
                    moves = (tail >= span) ? span : tail;
                    if (tail == 0)
                        truncations++;
                    else
                        fills_moved++;
                    for (k = 0; k < moves; k++)
                        set_entries[int'(lo) + k] = set_entries[set_count - moves + k];
                    set_count -= span;
                end
            end
            default:
            begin
                for (k = 0; k < set_count; k++)
                begin
                    if (k == 0 || set_entries[k] > best)
                        best = set_entries[k];
                end
                if (set_count > 0)
                    r.big = {1'b0, best};
            end
        endcase
        r.cnt = 9'(set_count);
        if (set_count > peak_count)
            peak_count = set_count;
        return r;
    endfunction

    // Index values lean toward a small pool, the extremes and stored entries so finds hit.
    function automatic logic [23:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return 24'($urandom_range(0, 7));
        else if (roll < 40)
        begin
            case ($urandom_range(0, 3))
                0:       return 24'h000000;
                1:       return 24'hFFFFFF;
                2:       return 24'h800000;
                default: return 24'h7FFFFF;
            endcase
        end
        else if (roll < 60 && set_count > 0)
            return set_entries[$urandom_range(0, set_count - 1)];
        else
            return 24'($urandom);
    endfunction

    function automatic int shape_for(int n);
        if (n < 150)
            return SHAPE_MIXED;
        else if (n < 450)
            return SHAPE_FILL;
        else if (n < 600)
            return SHAPE_DRAIN;
        else if (n < 800)
            return SHAPE_MIXED;
        else if (n < 1100)
            return SHAPE_FILL;
        else
            return SHAPE_DRAIN;
    endfunction

    // Choose one random request; most removes carry a legal range so the copy path is exercised.
    task automatic pick_request(input int shape, output iste_pkg::kind_t op,
                                output logic [23:0] v,
                                output logic [7:0] lo, output logic [7:0] hi);
        int roll;
        int reach;
        roll = $urandom_range(0, 99);
        v    = pick_value();
        lo   = 8'($urandom);
        hi   = 8'($urandom);
        if (roll < 5)
            op = iste_pkg::kind_t'($urandom_range(0, 3));
        else
        begin
            roll = $urandom_range(0, 99);
            case (shape)
                SHAPE_FILL:
                    op = (roll < 90) ? OP_APPEND : (roll < 95) ? OP_FIND :
                         (roll < 97) ? OP_REMOVE : OP_LARGEST;
                SHAPE_DRAIN:
                    op = (roll < 10) ? OP_APPEND : (roll < 20) ? OP_FIND :
                         (roll < 90) ? OP_REMOVE : OP_LARGEST;
                default:
                    op = (roll < 35) ? OP_APPEND : (roll < 60) ? OP_FIND :
                         (roll < 88) ? OP_REMOVE : OP_LARGEST;
            endcase
            if (op == OP_REMOVE && set_count > 0 && $urandom_range(0, 9) != 0)
            begin
                hi = 8'($urandom_range(0, set_count - 1));
                if ($urandom_range(0, 3) == 0)
                    hi = 8'(set_count - 1);
                reach = (shape == SHAPE_DRAIN) ? int'(hi) : ((hi < 4) ? int'(hi) : 4);
                lo = hi - 8'($urandom_range(0, reach));
            end
        end
    endtask

    // Hold a request on the ports until the engine takes it, then record what it must answer.
    task automatic issue(iste_pkg::kind_t op, logic [23:0] v, logic [7:0] lo, logic [7:0] hi,
                         logic typed, outcome_t typed_out);
        outcome_t predicted;
        start     <= 1'b1;
        kind      <= op;
        value     <= v;
        first_pos <= lo;
        last_pos  <= hi;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_to_set(op, v, lo, hi);
        if (typed)
            predicted = typed_out;
        predicted.tag = requests_sent;
        requests_sent++;
        results_due.push_back(predicted);
    endtask

    // Random pause between requests; sometimes long enough to outlast a full scan.
    task automatic maybe_pause(logic allowed);
        if (allowed && $urandom_range(0, 99) < 27)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? set_count + 6 : 4))
                @(posedge clk);
        end
    endtask

    // Check every result against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MAX)
                    $display("unexpected result: position %0d largest %0d count %0d error %0b",
                             position, largest_index, fill_count, error);
            end
            else
            begin
                want = results_due.pop_front();
                if (position !== want.pos || largest_index !== want.big ||
                    fill_count !== want.cnt || error !== want.err)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_MAX)
                        $display("request %0d: expected pos %0d largest %0d count %0d err %0b,",
                                 want.tag, $signed(want.pos), $signed(want.big), want.cnt,
                                 want.err,
                                 " got pos %0d largest %0d count %0d err %0b",
                                 position, largest_index, fill_count, error);
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("index_set_table_engine verification failed");
            $finish;
        end
    end

    initial
    begin
        outcome_t        typed_out;
        iste_pkg::kind_t op;
        logic [23:0]     v;
        logic [7:0]      lo;
        logic [7:0]      hi;
        int              n;

        // Directed requests; expected values are filled in where they are obvious.
        plan = '{
            '{OP_LARGEST, 24'h000000, 8'd0,   8'd0,   1'b1, NO_POSITION, NO_INDEX, 9'd0, 1'b0},
            '{OP_FIND,    24'h000000, 8'd0,   8'd0,   1'b1, NO_POSITION, NO_INDEX, 9'd0, 1'b0},
            '{OP_REMOVE,  24'h000000, 8'd0,   8'd0,   1'b1, NO_POSITION, NO_INDEX, 9'd0, 1'b1},
            '{OP_APPEND,  24'hFFFFFF, 8'd0,   8'd0,   1'b1, NO_POSITION, NO_INDEX, 9'd1, 1'b0},
            '{OP_APPEND,  24'h000000, 8'd0,   8'd0,   1'b1, NO_POSITION, NO_INDEX, 9'd2, 1'b0},
            '{OP_APPEND,  24'h000005, 8'd0,   8'd0,   1'b1, NO_POSITION, NO_INDEX, 9'd3, 1'b0},
            '{OP_APPEND,  24'h000005, 8'd0,   8'd0,   1'b1, NO_POSITION, NO_INDEX, 9'd4, 1'b0},
            '{OP_FIND,    24'h000005, 8'd0,   8'd0,   1'b1, 9'd2,        NO_INDEX, 9'd4, 1'b0},
            '{OP_FIND,    24'hFFFFFF, 8'd0,   8'd0,   1'b1, 9'd0,        NO_INDEX, 9'd4, 1'b0},
            '{OP_FIND,    24'h123456, 8'd0,   8'd0,   1'b1, NO_POSITION, NO_INDEX, 9'd4, 1'b0},
            '{OP_LARGEST, 24'h000000, 8'd0,   8'd0,   1'b1, NO_POSITION, 25'hFFFFFF, 9'd4, 1'b0},
            '{OP_REMOVE,  24'h000000, 8'd3,   8'd2,   1'b1, NO_POSITION, NO_INDEX, 9'd4, 1'b1},
            '{OP_REMOVE,  24'h000000, 8'd0,   8'd4,   1'b1, NO_POSITION, NO_INDEX, 9'd4, 1'b1},
            '{OP_REMOVE,  24'h000000, 8'd0,   8'd0,   1'b1, NO_POSITION, NO_INDEX, 9'd3, 1'b0},
            '{OP_FIND,    24'h000005, 8'd0,   8'd0,   1'b1, 9'd0,        NO_INDEX, 9'd3, 1'b0},
            '{OP_APPEND,  24'h800000, 8'd0,   8'd0,   1'b0, '0, '0, '0, 1'b0},
            '{OP_APPEND,  24'h7FFFFF, 8'd0,   8'd0,   1'b0, '0, '0, '0, 1'b0},
            '{OP_REMOVE,  24'h000000, 8'd1,   8'd3,   1'b0, '0, '0, '0, 1'b0},
            '{OP_LARGEST, 24'h000000, 8'd0,   8'd0,   1'b0, '0, '0, '0, 1'b0},
            '{OP_REMOVE,  24'h000000, 8'd1,   8'd1,   1'b0, '0, '0, '0, 1'b0},
            '{OP_REMOVE,  24'h000000, 8'd0,   8'd0,   1'b1, NO_POSITION, NO_INDEX, 9'd0, 1'b0},
            '{OP_LARGEST, 24'h000000, 8'd0,   8'd0,   1'b1, NO_POSITION, NO_INDEX, 9'd0, 1'b0},
            '{OP_APPEND,  24'hAAAAAA, 8'd255, 8'd255, 1'b0, '0, '0, '0, 1'b0},
            '{OP_REMOVE,  24'h555555, 8'd255, 8'd255, 1'b1, NO_POSITION, NO_INDEX, 9'd1, 1'b1},
            '{OP_FIND,    24'hAAAAAA, 8'd255, 8'd0,   1'b0, '0, '0, '0, 1'b0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (n = 0; n < DIRECTED; n++)
        begin
            typed_out = '{tag: 0, pos: plan[n].pos, big: plan[n].big,
                          cnt: plan[n].cnt, err: plan[n].err};
            issue(plan[n].op, plan[n].val, plan[n].lo, plan[n].hi, plan[n].typed, typed_out);
            maybe_pause(1'b1);
        end

        // Random traffic: fill, drain and mixed stretches; no pauses for requests 400 to 699.
        typed_out = '0;
        for (n = 0; n < RANDOM_REQS; n++)
        begin
            pick_request(shape_for(n), op, v, lo, hi);
            issue(op, v, lo, hi, 1'b0, typed_out);
            maybe_pause(n < 400 || n >= 700);
        end
        start <= 1'b0;

        while (results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Requests: %0d (append %0d, find %0d, remove %0d, largest %0d), peak fill %0d.",
                 requests_sent, kind_seen[OP_APPEND], kind_seen[OP_FIND],
                 kind_seen[OP_REMOVE], kind_seen[OP_LARGEST], peak_count);
        $display("Full rejects %0d, bad ranges %0d, truncations %0d, tail fills %0d, finds hit %0d.",
                 full_rejects, bad_ranges, truncations, fills_moved, finds_hit);
        if (mismatches == 0 && results_due.size() == 0)
            $display("index_set_table_engine verification clean");
        else
            $display("index_set_table_engine verification failed");
        $finish;
    end

endmodule
